### hw/rtl/stwbm_pkg.sv
package stwbm_pkg;

    localparam int STWBM_RESET_CLOCKS = 9;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_HALF_PERIOD  = 3'd0;
    localparam logic [2:0] REG_WAIT_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_CMD_TEMP     = 3'd2;
    localparam logic [2:0] REG_CMD_HUMID    = 3'd3;
    localparam logic [2:0] REG_CMD_STAT_WR  = 3'd4;
    localparam logic [2:0] REG_CMD_STAT_RD  = 3'd5;
    localparam logic [2:0] REG_CMD_SOFT_RST = 3'd6;

    // Action codes carried by a request.
    localparam logic [2:0] ACT_TEMP       = 3'd0;
    localparam logic [2:0] ACT_HUMID      = 3'd1;
    localparam logic [2:0] ACT_STAT_WRITE = 3'd2;
    localparam logic [2:0] ACT_STAT_READ  = 3'd3;
    localparam logic [2:0] ACT_SOFT_RESET = 3'd4;
    localparam logic [2:0] ACT_LINK_RESET = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_CR_HI,
        PH_CR_LO,
        PH_ST0,
        PH_ST1,
        PH_ST2,
        PH_ST3,
        PH_ST4,
        PH_ST5,
        PH_ST6,
        PH_WR_LO,
        PH_WR_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_WAIT,
        PH_RD_LO,
        PH_RD_HI,
        PH_RA_LO,
        PH_RA_HI
    } phase_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [23:0] wait_timeout_ticks;
        logic [7:0]  cmd_measure_temp;
        logic [7:0]  cmd_measure_humid;
        logic [7:0]  cmd_status_write;
        logic [7:0]  cmd_status_read;
        logic [7:0]  cmd_soft_reset;
    } cfg_t;

    typedef struct packed {
        logic       request;
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       data_line_in;
    } in_t;

    typedef struct packed {
        logic        sck_level;
        logic        data_pull_low;
        logic        busy_res;
        logic        done_res;
        logic        ack_missing;
        logic        ready_timeout;
        logic [15:0] measured_word;
        logic [7:0]  checksum_byte;
        logic [7:0]  status_byte;
    } out_t;

endpackage

### hw/rtl/sensor_two_wire_bus_master.sv
// A tick accepted on the input is held in the input register and written to the result
// register once the result register is empty or being read.
// Throughput: one tick per cycle while the result is not stalled; the whole bus step
// for a tick is one pass of the sequencer logic between the input and result registers.
// Reset: rst_n clears the sequencer to idle, all counters and flags to zero, and
// the configuration registers to their documented defaults.
module sensor_two_wire_bus_master
    import stwbm_pkg::*;
#(
    parameter int RESET_CLOCKS = STWBM_RESET_CLOCKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    in_t  in_data_reg;
    logic in_valid_reg;
    out_t out_data_reg;
    logic out_valid_reg;
    out_t res;
    logic advance;
    logic fire;

    // The result register can take a new value when it is empty or being read.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    stwbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stwbm_core #(
        .RESET_CLOCKS (RESET_CLOCKS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .item  (in_data_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= res;
        end
    end

endmodule

### hw/rtl/stwbm_regs.sv
module stwbm_regs
    import stwbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks  <= 16'd4;
            cfg_reg.wait_timeout_ticks <= 24'd1000000;
            cfg_reg.cmd_measure_temp   <= 8'd3;
            cfg_reg.cmd_measure_humid  <= 8'd5;
            cfg_reg.cmd_status_write   <= 8'd6;
            cfg_reg.cmd_status_read    <= 8'd7;
            cfg_reg.cmd_soft_reset     <= 8'd30;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HALF_PERIOD:  cfg_reg.half_period_ticks  <= pwdata[15:0];
                REG_WAIT_TIMEOUT: cfg_reg.wait_timeout_ticks <= pwdata[23:0];
                REG_CMD_TEMP:     cfg_reg.cmd_measure_temp   <= pwdata[7:0];
                REG_CMD_HUMID:    cfg_reg.cmd_measure_humid  <= pwdata[7:0];
                REG_CMD_STAT_WR:  cfg_reg.cmd_status_write   <= pwdata[7:0];
                REG_CMD_STAT_RD:  cfg_reg.cmd_status_read    <= pwdata[7:0];
                REG_CMD_SOFT_RST: cfg_reg.cmd_soft_reset     <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HALF_PERIOD:  prdata = {16'd0, cfg_reg.half_period_ticks};
            REG_WAIT_TIMEOUT: prdata = {8'd0, cfg_reg.wait_timeout_ticks};
            REG_CMD_TEMP:     prdata = {24'd0, cfg_reg.cmd_measure_temp};
            REG_CMD_HUMID:    prdata = {24'd0, cfg_reg.cmd_measure_humid};
            REG_CMD_STAT_WR:  prdata = {24'd0, cfg_reg.cmd_status_write};
            REG_CMD_STAT_RD:  prdata = {24'd0, cfg_reg.cmd_status_read};
            REG_CMD_SOFT_RST: prdata = {24'd0, cfg_reg.cmd_soft_reset};
            default:          prdata = '0;
        endcase
    end

endmodule

### hw/rtl/stwbm_core.sv
module stwbm_core
    import stwbm_pkg::*;
#(
    parameter int RESET_CLOCKS = STWBM_RESET_CLOCKS
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic fire,
    input  in_t  item,
    output out_t res
);

    localparam int BitCntW = ($clog2(RESET_CLOCKS) > 4) ? $clog2(RESET_CLOCKS) : 4;

    phase_t               phase_reg, phase_next;
    logic [15:0]          tdiv_reg, tdiv_next;
    logic [BitCntW-1:0]   bitcnt_reg, bitcnt_next;
    logic [1:0]           bytecnt_reg, bytecnt_next;
    logic [7:0]           shifter_reg, shifter_next;
    logic [23:0]          wait_cnt_reg, wait_cnt_next;
    logic [15:0]          word_reg, word_next;
    logic [1:0]           err_reg, err_next;
    logic [2:0]           action_reg, action_next;
    logic                 done;

    logic [15:0]          hp;
    logic [23:0]          to;
    logic [16:0]          tsum;
    logic [24:0]          wsum;
    logic [BitCntW:0]     bsum;
    logic [1:0]           last_read;
    logic                 more_reads;
    logic [7:0]           command;
    logic                 sck;
    logic                 pull;
    logic                 is_meas;
    logic                 is_sread;

    // A zero half period or timeout behaves as one tick.
    assign hp   = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
    assign to   = (cfg.wait_timeout_ticks == '0) ? 24'd1 : cfg.wait_timeout_ticks;
    assign tsum = {1'b0, tdiv_reg} + 17'd1;
    assign wsum = {1'b0, wait_cnt_reg} + 25'd1;
    assign bsum = {1'b0, bitcnt_reg} + {{BitCntW{1'b0}}, 1'b1};

    assign is_meas    = (action_reg == ACT_TEMP) || (action_reg == ACT_HUMID);
    assign is_sread   = (action_reg == ACT_STAT_READ);
    assign last_read  = is_sread ? 2'd1 : 2'd2;
    assign more_reads = bytecnt_reg < last_read;

    always_comb
    begin
        case (action_reg)
            ACT_TEMP:       command = cfg.cmd_measure_temp;
            ACT_HUMID:      command = cfg.cmd_measure_humid;
            ACT_STAT_WRITE: command = cfg.cmd_status_write;
            ACT_STAT_READ:  command = cfg.cmd_status_read;
            default:        command = cfg.cmd_soft_reset;
        endcase
    end

    // Pin levels of the current slot.
    always_comb
    begin
        sck  = 1'b0;
        pull = 1'b0;
        case (phase_reg)
            PH_CR_HI, PH_ST1, PH_ST5, PH_ACK_HI, PH_RD_HI: sck = 1'b1;
            PH_ST2, PH_ST4:
            begin
                sck  = 1'b1;
                pull = 1'b1;
            end
            PH_ST3:   pull = 1'b1;
            PH_WR_LO: pull = ~shifter_reg[7];
            PH_WR_HI:
            begin
                sck  = 1'b1;
                pull = ~shifter_reg[7];
            end
            PH_RA_LO: pull = more_reads;
            PH_RA_HI:
            begin
                sck  = 1'b1;
                pull = more_reads;
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tdiv_next     = tdiv_reg;
        bitcnt_next   = bitcnt_reg;
        bytecnt_next  = bytecnt_reg;
        shifter_next  = shifter_reg;
        wait_cnt_next = wait_cnt_reg;
        word_next     = word_reg;
        err_next      = err_reg;
        action_next   = action_reg;
        done          = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.request && (item.action <= ACT_LINK_RESET))
            begin
                action_next   = item.action;
                err_next      = '0;
                tdiv_next     = '0;
                bitcnt_next   = '0;
                bytecnt_next  = '0;
                wait_cnt_next = '0;
                shifter_next  = '0;
                word_next     = (item.action == ACT_STAT_WRITE) ? {8'd0, item.tx_byte} : 16'd0;
                phase_next    = (item.action >= ACT_SOFT_RESET) ? PH_CR_HI : PH_ST0;
            end
        end
        else if (phase_reg == PH_WAIT)
        begin
            // The ready wait counts ticks, not slots.
            if (!item.data_line_in || (wsum >= {1'b0, to}))
            begin
                if (item.data_line_in)
                begin
                    err_next[1] = 1'b1;
                end
                wait_cnt_next = '0;
                bytecnt_next  = '0;
                bitcnt_next   = '0;
                tdiv_next     = '0;
                phase_next    = PH_RD_LO;
            end
            else
            begin
                wait_cnt_next = wsum[23:0];
            end
        end
        else if (tsum < {1'b0, hp})
        begin
            tdiv_next = tsum[15:0];
        end
        else
        begin
            tdiv_next = '0;
            case (phase_reg)
                PH_CR_HI: phase_next = PH_CR_LO;
                PH_CR_LO:
                begin
                    if (bsum >= (BitCntW+1)'(RESET_CLOCKS))
                    begin
                        bitcnt_next = '0;
                        phase_next  = PH_ST0;
                    end
                    else
                    begin
                        bitcnt_next = bsum[BitCntW-1:0];
                        phase_next  = PH_CR_HI;
                    end
                end
                PH_ST0: phase_next = PH_ST1;
                PH_ST1: phase_next = PH_ST2;
                PH_ST2: phase_next = PH_ST3;
                PH_ST3: phase_next = PH_ST4;
                PH_ST4: phase_next = PH_ST5;
                PH_ST5: phase_next = PH_ST6;
                PH_ST6:
                begin
                    if (action_reg == ACT_LINK_RESET)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        shifter_next = command;
                        bitcnt_next  = '0;
                        phase_next   = PH_WR_LO;
                    end
                end
                PH_WR_LO: phase_next = PH_WR_HI;
                PH_WR_HI:
                begin
                    shifter_next = {shifter_reg[6:0], 1'b0};
                    if (bsum >= (BitCntW+1)'(8))
                    begin
                        bitcnt_next = '0;
                        phase_next  = PH_ACK_LO;
                    end
                    else
                    begin
                        bitcnt_next = bsum[BitCntW-1:0];
                        phase_next  = PH_WR_LO;
                    end
                end
                PH_ACK_LO: phase_next = PH_ACK_HI;
                PH_ACK_HI:
                begin
                    if (item.data_line_in)
                    begin
                        err_next[0] = 1'b1;
                    end
                    if ((action_reg == ACT_STAT_WRITE) && (bytecnt_reg == 2'd0))
                    begin
                        bytecnt_next = 2'd1;
                        shifter_next = word_reg[7:0];
                        bitcnt_next  = '0;
                        phase_next   = PH_WR_LO;
                    end
                    else if (is_meas)
                    begin
                        wait_cnt_next = '0;
                        phase_next    = PH_WAIT;
                    end
                    else if (is_sread)
                    begin
                        bytecnt_next = '0;
                        bitcnt_next  = '0;
                        phase_next   = PH_RD_LO;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_RD_LO: phase_next = PH_RD_HI;
                PH_RD_HI:
                begin
                    shifter_next = {shifter_reg[6:0], item.data_line_in};
                    if (bsum >= (BitCntW+1)'(8))
                    begin
                        bitcnt_next = '0;
                        phase_next  = PH_RA_LO;
                    end
                    else
                    begin
                        bitcnt_next = bsum[BitCntW-1:0];
                        phase_next  = PH_RD_LO;
                    end
                end
                PH_RA_LO: phase_next = PH_RA_HI;
                PH_RA_HI:
                begin
                    if (more_reads)
                    begin
                        if (is_sread)
                        begin
                            word_next = {8'd0, shifter_reg};
                        end
                        else if (bytecnt_reg == 2'd0)
                        begin
                            word_next = {shifter_reg, 8'd0};
                        end
                        else
                        begin
                            word_next = word_reg | {8'd0, shifter_reg};
                        end
                        bytecnt_next = bytecnt_reg + 2'd1;
                        phase_next   = PH_RD_LO;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // A finishing slot leaves the word and shift registers untouched, so the
    // result fields come from their present contents.
    always_comb
    begin
        res.sck_level     = sck;
        res.data_pull_low = pull;
        res.busy_res      = (phase_reg != PH_IDLE);
        res.done_res      = done;
        res.ack_missing   = err_next[0];
        res.ready_timeout = err_next[1];
        res.measured_word = (done && is_meas) ? word_reg : 16'd0;
        res.checksum_byte = (done && (is_meas || is_sread)) ? shifter_reg : 8'd0;
        res.status_byte   = (done && is_sread) ? word_reg[7:0] : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tdiv_reg     <= '0;
            bitcnt_reg   <= '0;
            bytecnt_reg  <= '0;
            shifter_reg  <= '0;
            wait_cnt_reg <= '0;
            word_reg     <= '0;
            err_reg      <= '0;
            action_reg   <= ACT_TEMP;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            tdiv_reg     <= tdiv_next;
            bitcnt_reg   <= bitcnt_next;
            bytecnt_reg  <= bytecnt_next;
            shifter_reg  <= shifter_next;
            wait_cnt_reg <= wait_cnt_next;
            word_reg     <= word_next;
            err_reg      <= err_next;
            action_reg   <= action_next;
        end
    end

    // A finished transaction always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after done");

    // The slot divider never passes the half period while busy.
    a_tdiv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tdiv_reg < hp))
        else $error("tick divider out of range");

    // Bit counter stays inside a byte during byte transfers.
    a_bitcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_WR_LO) || (phase_reg == PH_WR_HI) ||
         (phase_reg == PH_RD_LO) || (phase_reg == PH_RD_HI))
        |-> (bitcnt_reg < BitCntW'(8)))
        else $error("bit counter out of range");

    // Error flags only change on a fired tick.
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(err_reg))
        else $error("error flags changed without a tick");

endmodule

### tb/sensor_two_wire_bus_master_tb.sv
module sensor_two_wire_bus_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stwbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_t                  out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sensor_two_wire_bus_master u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Local copy of the bus master's configuration and sequencer state.
    cfg_t        bus_cfg = '{16'd4, 24'd1000000, 8'd3, 8'd5, 8'd6, 8'd7, 8'd30};
    phase_t      seq_phase = PH_IDLE;
    logic [15:0] slot_ticks = '0;
    logic [3:0]  bit_idx = '0;
    logic [1:0]  byte_idx = '0;
    logic [7:0]  shift_byte = '0;
    logic [23:0] ready_wait = '0;
    logic [15:0] data_word = '0;
    logic [1:0]  err_flags = '0;
    logic [2:0]  running_act = ACT_TEMP;

    in_t  ticks_to_send[$];
    out_t pin_results_due[$];
    out_t want_res;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int cycle_count = 0;
    int ticks_checked = 0;
    int actions_started = 0;
    int actions_done = 0;
    int nack_done = 0;
    int timeout_done = 0;
    int settings_used = 1;

    // One tick of the bus master: pin levels of the current slot, then the state update.
    function automatic out_t bus_step(in_t t);
        out_t r;
        int   hp;
        int   lim;
        logic more_rd;
        logic fin;
        r = '0;
        fin = 1'b0;
        hp = (bus_cfg.half_period_ticks == 0) ? 1 : int'(bus_cfg.half_period_ticks);
        lim = (bus_cfg.wait_timeout_ticks == 0) ? 1 : int'(bus_cfg.wait_timeout_ticks);
        // A status read takes one byte before the checksum, a measurement two.
        more_rd = byte_idx < ((running_act == ACT_STAT_READ) ? 2'd1 : 2'd2);

        case (seq_phase)
            PH_CR_HI, PH_ST1, PH_ST5, PH_ACK_HI, PH_RD_HI:
                r.sck_level = 1'b1;
            PH_ST2, PH_ST4:
            begin
                r.sck_level = 1'b1;
                r.data_pull_low = 1'b1;
            end
            PH_ST3:
                r.data_pull_low = 1'b1;
            PH_WR_LO:
                r.data_pull_low = ~shift_byte[7];
            PH_WR_HI:
            begin
                r.sck_level = 1'b1;
                r.data_pull_low = ~shift_byte[7];
            end
            PH_RA_LO:
                r.data_pull_low = more_rd;
            PH_RA_HI:
            begin
                r.sck_level = 1'b1;
                r.data_pull_low = more_rd;
            end
            default: ;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);

        if (seq_phase == PH_IDLE) begin
            if (t.request && t.action <= ACT_LINK_RESET) begin
                running_act = t.action;
                err_flags = '0;
                slot_ticks = '0;
                bit_idx = '0;
                byte_idx = '0;
                ready_wait = '0;
                shift_byte = '0;
                data_word = (t.action == ACT_STAT_WRITE) ? {8'h00, t.tx_byte} : 16'h0000;
                seq_phase = (t.action >= ACT_SOFT_RESET) ? PH_CR_HI : PH_ST0;
                actions_started++;
            end
        end else if (seq_phase == PH_WAIT) begin
            // The ready wait counts ticks, not slots.
            if (!t.data_line_in || int'(ready_wait) + 1 >= lim) begin
                if (t.data_line_in)
                    err_flags[1] = 1'b1;
                ready_wait = '0;
                byte_idx = '0;
                bit_idx = '0;
                slot_ticks = '0;
                seq_phase = PH_RD_LO;
            end else begin
                ready_wait = ready_wait + 1'b1;
            end
        end else if (int'(slot_ticks) + 1 < hp) begin
            slot_ticks = slot_ticks + 1'b1;
        end else begin
            slot_ticks = '0;
            case (seq_phase)
                PH_CR_HI:
                    seq_phase = PH_CR_LO;
                PH_CR_LO:
                begin
                    if (int'(bit_idx) + 1 >= STWBM_RESET_CLOCKS) begin
                        bit_idx = '0;
                        seq_phase = PH_ST0;
                    end else begin
                        bit_idx = bit_idx + 1'b1;
                        seq_phase = PH_CR_HI;
                    end
                end
                PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5:
                    seq_phase = phase_t'(seq_phase + 5'd1);
                PH_ST6:
                begin
                    if (running_act == ACT_LINK_RESET) begin
                        fin = 1'b1;
                    end else begin
                        case (running_act)
                            ACT_TEMP:       shift_byte = bus_cfg.cmd_measure_temp;
                            ACT_HUMID:      shift_byte = bus_cfg.cmd_measure_humid;
                            ACT_STAT_WRITE: shift_byte = bus_cfg.cmd_status_write;
                            ACT_STAT_READ:  shift_byte = bus_cfg.cmd_status_read;
                            default:        shift_byte = bus_cfg.cmd_soft_reset;
                        endcase
                        bit_idx = '0;
                        seq_phase = PH_WR_LO;
                    end
                end
                PH_WR_LO:
                    seq_phase = PH_WR_HI;
                PH_WR_HI:
                begin
                    shift_byte = {shift_byte[6:0], 1'b0};
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx >= 4'd8) begin
                        bit_idx = '0;
                        seq_phase = PH_ACK_LO;
                    end else begin
                        seq_phase = PH_WR_LO;
                    end
                end
                PH_ACK_LO:
                    seq_phase = PH_ACK_HI;
                PH_ACK_HI:
                begin
                    if (t.data_line_in)
                        err_flags[0] = 1'b1;
                    if (running_act == ACT_STAT_WRITE && byte_idx == 2'd0) begin
                        byte_idx = 2'd1;
                        shift_byte = data_word[7:0];
                        bit_idx = '0;
                        seq_phase = PH_WR_LO;
                    end else if (running_act == ACT_TEMP || running_act == ACT_HUMID) begin
                        ready_wait = '0;
                        seq_phase = PH_WAIT;
                    end else if (running_act == ACT_STAT_READ) begin
                        byte_idx = '0;
                        bit_idx = '0;
                        seq_phase = PH_RD_LO;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_RD_LO:
                    seq_phase = PH_RD_HI;
                PH_RD_HI:
                begin
                    shift_byte = {shift_byte[6:0], t.data_line_in};
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx >= 4'd8) begin
                        bit_idx = '0;
                        seq_phase = PH_RA_LO;
                    end else begin
                        seq_phase = PH_RD_LO;
                    end
                end
                PH_RA_LO:
                    seq_phase = PH_RA_HI;
                PH_RA_HI:
                begin
                    if (more_rd) begin
                        if (running_act == ACT_STAT_READ)
                            data_word = {8'h00, shift_byte};
                        else if (byte_idx == 2'd0)
                            data_word = {shift_byte, 8'h00};
                        else
                            data_word = data_word | {8'h00, shift_byte};
                        byte_idx = byte_idx + 1'b1;
                        seq_phase = PH_RD_LO;
                    end else begin
                        fin = 1'b1;
                    end
                end
                default:
                    seq_phase = PH_IDLE;
            endcase
        end

        if (fin)
            seq_phase = PH_IDLE;
        r.done_res = fin;
        r.ack_missing = err_flags[0];
        r.ready_timeout = err_flags[1];
        if (fin) begin
            actions_done++;
            if (err_flags[0])
                nack_done++;
            if (err_flags[1])
                timeout_done++;
            if (running_act == ACT_TEMP || running_act == ACT_HUMID) begin
                r.measured_word = data_word;
                r.checksum_byte = shift_byte;
            end else if (running_act == ACT_STAT_READ) begin
                r.checksum_byte = shift_byte;
                r.status_byte = data_word[7:0];
            end
        end
        return r;
    endfunction

    function automatic in_t make_tick(logic req, logic [2:0] act, logic [7:0] tx, logic din);
        in_t t;
        t.request = req;
        t.action = act;
        t.tx_byte = tx;
        t.data_line_in = din;
        return t;
    endfunction

    function automatic in_t random_tick(int req_pct, int din_hi_pct);
        logic [2:0] act;
        // Codes above the link reset are invalid and must leave the master idle.
        if ($urandom_range(0, 9) == 0)
            act = {2'b11, 1'($urandom)};
        else
            act = 3'($urandom_range(int'(ACT_TEMP), int'(ACT_LINK_RESET)));
        return make_tick($urandom_range(0, 99) < req_pct, act, 8'($urandom),
                         $urandom_range(0, 99) < din_hi_pct);
    endfunction

    function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
        end
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Tick driver: a new tick is offered only when none is held or the held one is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && !in_stall)
                pin_results_due.push_back(bus_step(in_data));
            if (!in_valid || !in_stall) begin
                if (ticks_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= ticks_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pin_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with no tick pending, actual %0h",
                             $time, out_data);
                end else begin
                    want_res = pin_results_due.pop_front();
                    ticks_checked++;
                    check_field("sck_level", want_res.sck_level, out_data.sck_level);
                    check_field("data_pull_low", want_res.data_pull_low,
                                out_data.data_pull_low);
                    check_field("busy_res", want_res.busy_res, out_data.busy_res);
                    check_field("done_res", want_res.done_res, out_data.done_res);
                    check_field("ack_missing", want_res.ack_missing, out_data.ack_missing);
                    check_field("ready_timeout", want_res.ready_timeout,
                                out_data.ready_timeout);
                    check_field("measured_word", want_res.measured_word,
                                out_data.measured_word);
                    check_field("checksum_byte", want_res.checksum_byte,
                                out_data.checksum_byte);
                    check_field("status_byte", want_res.status_byte, out_data.status_byte);
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic csr_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HALF_PERIOD:  bus_cfg.half_period_ticks = val[15:0];
            REG_WAIT_TIMEOUT: bus_cfg.wait_timeout_ticks = val[23:0];
            REG_CMD_TEMP:     bus_cfg.cmd_measure_temp = val[7:0];
            REG_CMD_HUMID:    bus_cfg.cmd_measure_humid = val[7:0];
            REG_CMD_STAT_WR:  bus_cfg.cmd_status_write = val[7:0];
            REG_CMD_STAT_RD:  bus_cfg.cmd_status_read = val[7:0];
            REG_CMD_SOFT_RST: bus_cfg.cmd_soft_reset = val[7:0];
            default: ;
        endcase
    endtask

    task automatic write_bus_setting(logic [15:0] hp, logic [23:0] lim, logic [7:0] c_temp,
                                     logic [7:0] c_humid, logic [7:0] c_wr, logic [7:0] c_rd,
                                     logic [7:0] c_soft);
        repeat (4) @(posedge clk);
        csr_write(REG_HALF_PERIOD, {16'h0, hp});
        csr_write(REG_WAIT_TIMEOUT, {8'h0, lim});
        csr_write(REG_CMD_TEMP, {24'h0, c_temp});
        csr_write(REG_CMD_HUMID, {24'h0, c_humid});
        csr_write(REG_CMD_STAT_WR, {24'h0, c_wr});
        csr_write(REG_CMD_STAT_RD, {24'h0, c_rd});
        csr_write(REG_CMD_SOFT_RST, {24'h0, c_soft});
        settings_used++;
    endtask

    task automatic wait_quiet();
        while (ticks_to_send.size() != 0 || in_valid || pin_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Feed plain ticks until the running action has finished, so registers can be written.
    task automatic drain_to_idle();
        wait_quiet();
        while (seq_phase != PH_IDLE) begin
            repeat (40)
                ticks_to_send.push_back(random_tick(0, 50));
            wait_quiet();
        end
    endtask

    task automatic queue_random(int n, int req_pct, int din_hi_pct);
        repeat (n)
            ticks_to_send.push_back(random_tick(req_pct, din_hi_pct));
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, no idling: invalid codes, field extremes, requests while busy.
        send_idle_pct = 0;
        stall_pct = 0;
        ticks_to_send.push_back(make_tick(1'b0, 3'b111, 8'hFF, 1'b1));
        ticks_to_send.push_back(make_tick(1'b1, 3'b110, 8'h00, 1'b0));
        ticks_to_send.push_back(make_tick(1'b1, 3'b111, 8'hFF, 1'b1));
        ticks_to_send.push_back(make_tick(1'b0, ACT_TEMP, 8'h00, 1'b0));
        ticks_to_send.push_back(make_tick(1'b1, ACT_LINK_RESET, 8'hA5, 1'b1));
        for (int k = 0; k < 20; k++)
            ticks_to_send.push_back(make_tick(1'b1, 3'(int'(ACT_TEMP) + k % 5),
                                              8'(k * 37), k[0]));
        queue_random(60, 20, 50);
        drain_to_idle();

        // Zero half period and zero timeout; DATA mostly high gives timeouts and missing acks.
        write_bus_setting(16'h0000, 24'h000000, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_idle_pct = 46;
        stall_pct = 0;
        queue_random(130, 30, 85);
        drain_to_idle();

        write_bus_setting(16'h0001, 24'hFFFFFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_idle_pct = 0;
        stall_pct = 46;
        queue_random(130, 30, 50);
        drain_to_idle();

        write_bus_setting(16'h0002, 24'h000003, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
        send_idle_pct = 38;
        stall_pct = 38;
        queue_random(130, 30, 20);
        drain_to_idle();

        // Longest half period: only the first slots of one action fit in the run.
        write_bus_setting(16'hFFFF, 24'h000001, 8'h03, 8'h05, 8'h06, 8'h07, 8'h1E);
        send_idle_pct = 0;
        stall_pct = 0;
        ticks_to_send.push_back(make_tick(1'b1, ACT_TEMP, 8'($urandom), 1'b0));
        queue_random(24, 30, 50);
        wait_quiet();
        repeat (10) @(posedge clk);

        $display("Checked %0d ticks over %0d bus settings.", ticks_checked, settings_used);
        $display("Actions: %0d started, %0d finished, %0d missing ack, %0d ready timeout.",
                 actions_started, actions_done, nack_done, timeout_done);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/stwbm_pkg.sv
hw/rtl/stwbm_regs.sv
hw/rtl/stwbm_core.sv
hw/rtl/sensor_two_wire_bus_master.sv
tb/sensor_two_wire_bus_master_tb.sv
